// ===== src/bblur_pkg.sv =====
// ----------------------------------------------------------------------------
// bblur_pkg
// Types, constants, the channel sum helpers and the divide-by-nine helper shared by the box blur.
// ----------------------------------------------------------------------------
package bblur_pkg;

   localparam int CH_W     = 16;
   localparam int SUM_W    = 20;   // nine 16-bit values
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;

   localparam int CFG_RESET_DIM = 256;

   // floor(x / 9) == (x * DIV9_MULT) >> DIV9_SHIFT for x below 2^21
   localparam int DIV9_SHIFT = 23;
   localparam logic [SUM_W-1:0] DIV9_MULT = 20'd932068;
   localparam int DIV9_PROD_W = 2 * SUM_W + 1;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } cell_type;

   typedef struct packed {
      cell_type upper;
      cell_type middle;
   } line_pair_type;

   typedef struct packed {
      cell_type up;
      cell_type md;
      cell_type dn;
   } column_type;

   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } sum_type;

   typedef struct packed {
      logic advance;     // item leaves the work stage
      logic first_col;   // item sits in column zero
      logic last;        // item closes the frame
      logic clear;       // configuration write restarts the frame
   } win_ctl_type;

   function automatic sum_type column_sum(input column_type col);
      sum_type s;
      s.red   = SUM_W'(col.up.red)   + SUM_W'(col.md.red)   + SUM_W'(col.dn.red);
      s.green = SUM_W'(col.up.green) + SUM_W'(col.md.green) + SUM_W'(col.dn.green);
      s.blue  = SUM_W'(col.up.blue)  + SUM_W'(col.md.blue)  + SUM_W'(col.dn.blue);
      return s;
   endfunction

   function automatic sum_type sum_add(input sum_type a, input sum_type b);
      sum_type s;
      s.red   = a.red + b.red;
      s.green = a.green + b.green;
      s.blue  = a.blue + b.blue;
      return s;
   endfunction

   // round to nearest: (s + 4) / 9
   function automatic logic [CH_W-1:0] avg9(input logic [SUM_W-1:0] s);
      logic [SUM_W:0]         x;
      logic [DIV9_PROD_W-1:0] prod;
      x    = (SUM_W+1)'(s) + (SUM_W+1)'(4);
      prod = DIV9_PROD_W'(x) * DIV9_PROD_W'(DIV9_MULT);
      return prod[DIV9_SHIFT +: CH_W];
   endfunction

endpackage

// ===== src/bblur_line_mem.sv =====
// ----------------------------------------------------------------------------
// bblur_line_mem
// Paired line store: upper and middle rows in one wide memory, registered read.
// ----------------------------------------------------------------------------
module bblur_line_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                    clock,
   input  logic                    rd_en,
   input  logic [AW-1:0]           rd_addr,
   output bblur_pkg::line_pair_type rd_data,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  bblur_pkg::line_pair_type wr_data
);
   import bblur_pkg::*;

   line_pair_type mem [DEPTH];
   line_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bblur_window.sv =====
// ----------------------------------------------------------------------------
// bblur_window
// 3x3 window of columns, nine-cell channel sums and the rounded average.
// ----------------------------------------------------------------------------
module bblur_window (
   input  logic                  clock,
   input  logic                  reset,
   input  bblur_pkg::win_ctl_type ctl,
   input  bblur_pkg::column_type  new_col,
   output bblur_pkg::cell_type    avg
);
   import bblur_pkg::*;

   column_type win_ff [2];   // two older columns, index 1 newer
   column_type win_in [2];
   sum_type    sum_old;
   sum_type    sum_all;

   always_comb begin
      win_in = win_ff;
      if (ctl.clear) begin
         win_in[0] = '0;
         win_in[1] = '0;
      end else if (ctl.advance) begin
         if (ctl.last) begin
            win_in[0] = '0;
            win_in[1] = '0;
         end else if (ctl.first_col) begin
            win_in[0] = '0;
            win_in[1] = new_col;
         end else begin
            win_in[0] = win_ff[1];
            win_in[1] = new_col;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff[0] <= '0;
         win_ff[1] <= '0;
      end else begin
         win_ff <= win_in;
      end
   end

   // Column zero closes the previous row: its right neighbor is off frame.
   always_comb begin
      sum_old = sum_add(column_sum(win_ff[0]), column_sum(win_ff[1]));
      sum_all = ctl.first_col ? sum_old : sum_add(sum_old, column_sum(new_col));
      avg.red   = avg9(sum_all.red);
      avg.green = avg9(sum_all.green);
      avg.blue  = avg9(sum_all.blue);
   end

endmodule

// ===== src/box_blur_3x3_rgb.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// Streaming 3x3 box average over a raster frame of RGB cells.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries pixels in raster order, one transaction per cell. After the
//    W*H frame pixels send W+1 flush transactions (req_mode = 1) to drain.
//  - rsp_* returns the averaged cell one row and one column behind the input;
//    the first W+1 transactions of a frame produce no response. rsp_frame_end
//    marks the response for the bottom right cell, after which a new frame
//    begins.
//  - csr_* writes frame_width (index 0) and frame_height (index 1); values are
//    clamped to [2, MAX]. A write restarts the frame. Write only while idle.
//  - Path: an accepted transaction waits in the work register; its response is
//    loaded into the response register when it leaves the work stage.
//  - Throughput: one transaction per cycle while req_stall is low; the line
//    memory is read on accept, written back when it leaves the work stage.
//  - rsp_stall holds the response register; the work register then holds one
//    more transaction and req_stall rises until the response is taken.
//  - Reset clears positions, window and valids; width and height load 256, or
//    MAX if smaller. Line memory data read before it is written is never used.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   // input channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_mode,
   input  logic [bblur_pkg::CH_W-1:0]       req_red_in,
   input  logic [bblur_pkg::CH_W-1:0]       req_green_in,
   input  logic [bblur_pkg::CH_W-1:0]       req_blue_in,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [bblur_pkg::CH_W-1:0]       rsp_red_out,
   output logic [bblur_pkg::CH_W-1:0]       rsp_green_out,
   output logic [bblur_pkg::CH_W-1:0]       rsp_blue_out,
   output logic                             rsp_frame_end,
   // configuration
   input  logic                             csr_wr_en,
   input  logic [bblur_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bblur_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bblur_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);        // column / memory address
   localparam int WW = $clog2(MAX_WIDTH + 1);    // effective width
   localparam int HW = $clog2(MAX_HEIGHT + 1);   // effective height
   localparam int RW = $clog2(MAX_HEIGHT + 2);   // row, runs to height + 1
   localparam int DEF_W = (CFG_RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : CFG_RESET_DIM;
   localparam int DEF_H = (CFG_RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : CFG_RESET_DIM;

   typedef struct packed {
      cell_type        pix;        // already zeroed for flush / off-frame rows
      logic [CW-1:0]   col;
      logic            first_col;
      logic            top_en;
      logic            mid_en;
      logic            emit;
      logic            last;
   } work_type;

   // configuration
   logic [WW-1:0] width_ff, width_in;
   logic [HW-1:0] height_ff, height_in;
   logic [WW-1:0] wdata_width;
   logic [HW-1:0] wdata_height;

   // positions of the next transaction to accept
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // work stage and response register
   logic          work_valid_ff, work_valid_in;
   work_type      work_ff, work_in;
   logic          out_valid_ff, out_valid_in;
   cell_type      out_cell_ff, out_cell_in;
   logic          out_end_ff, out_end_in;

   logic          accept;
   logic          advance;
   logic          at_last;
   logic          wrap;
   logic [RW-1:0] height_row;

   line_pair_type rd_pair;
   line_pair_type wr_pair;
   column_type    new_col;
   win_ctl_type   win_ctl;
   cell_type      avg;

   // ---------------------------------------------------------------- handshake
   assign advance   = work_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = work_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // ---------------------------------------------------------------- clamp
   always_comb begin
      if (csr_wdata < CSR_DATA_W'(2)) begin
         wdata_width  = WW'(2);
         wdata_height = HW'(2);
      end else begin
         wdata_width  = (32'(csr_wdata) > 32'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : WW'(csr_wdata);
         wdata_height = (32'(csr_wdata) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(csr_wdata);
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         if (csr_index == CSR_FRAME_WIDTH) begin
            width_in = wdata_width;
         end else begin
            height_in = wdata_height;
         end
      end
   end

   // ---------------------------------------------------------------- position
   assign height_row = RW'(height_ff);
   assign at_last    = (row_ff == height_row + RW'(1)) && (col_ff == '0);
   assign wrap       = ((CW + 1)'(col_ff) + (CW + 1)'(1)) >= (CW + 1)'(width_ff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_wr_en) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (at_last) begin
            col_in = '0;
            row_in = '0;
         end else if (wrap) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   // ---------------------------------------------------------------- work stage
   always_comb begin
      work_valid_in = work_valid_ff;
      work_in       = work_ff;
      if (accept) begin
         work_valid_in     = 1'b1;
         work_in.pix.red   = req_red_in;
         work_in.pix.green = req_green_in;
         work_in.pix.blue  = req_blue_in;
         // drop the value of flush items and anything past the last row
         if (req_mode || (row_ff >= height_row)) begin
            work_in.pix = '0;
         end
         work_in.col       = col_ff;
         work_in.first_col = (col_ff == '0);
         work_in.top_en    = (row_ff >= RW'(2));
         work_in.mid_en    = (row_ff >= RW'(1)) && (row_ff <= height_row);
         work_in.emit      = (row_ff >= RW'(2)) || ((row_ff == RW'(1)) && (col_ff != '0));
         work_in.last      = at_last;
      end else if (advance) begin
         work_valid_in = 1'b0;
      end
   end

   bblur_line_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_pair),
      .wr_en   (advance),
      .wr_addr (work_ff.col),
      .wr_data (wr_pair)
   );

   // shift the column down one row in the line memory
   assign wr_pair.upper  = rd_pair.middle;
   assign wr_pair.middle = work_ff.pix;

   assign new_col.up = work_ff.top_en ? rd_pair.upper  : '0;
   assign new_col.md = work_ff.mid_en ? rd_pair.middle : '0;
   assign new_col.dn = work_ff.pix;

   assign win_ctl.advance   = advance;
   assign win_ctl.first_col = work_ff.first_col;
   assign win_ctl.last      = work_ff.last;
   assign win_ctl.clear     = csr_wr_en;

   bblur_window u_window (
      .clock   (clock),
      .reset   (reset),
      .ctl     (win_ctl),
      .new_col (new_col),
      .avg     (avg)
   );

   // ---------------------------------------------------------------- response
   always_comb begin
      out_valid_in = out_valid_ff;
      out_cell_in  = out_cell_ff;
      out_end_in   = out_end_ff;
      if (advance) begin
         out_valid_in = work_ff.emit;
         out_cell_in  = avg;
         out_end_in   = work_ff.last;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= WW'(DEF_W);
         height_ff     <= HW'(DEF_H);
         col_ff        <= '0;
         row_ff        <= '0;
         work_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         work_valid_ff <= work_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      out_cell_ff <= out_cell_in;
      out_end_ff  <= out_end_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_red_out   = out_cell_ff.red;
   assign rsp_green_out = out_cell_ff.green;
   assign rsp_blue_out  = out_cell_ff.blue;
   assign rsp_frame_end = out_end_ff;

`ifndef SYNTHESIS
   a_col_in_frame : assert property (@(posedge clock) disable iff (reset)
      (WW + 1)'(col_ff) < (WW + 1)'(width_ff))
      else $error("column position beyond frame width");

   a_row_bound : assert property (@(posedge clock) disable iff (reset)
      row_ff <= height_row + RW'(1))
      else $error("row position beyond flush row");

   a_last_restarts : assert property (@(posedge clock) disable iff (reset)
      (accept && at_last && !csr_wr_en) |=> (col_ff == '0) && (row_ff == '0) && work_ff.last)
      else $error("frame did not restart after its last transaction");

   a_emit_shows : assert property (@(posedge clock) disable iff (reset)
      (advance && work_ff.emit) |=> (rsp_valid && (rsp_frame_end == $past(work_ff.last))))
      else $error("emitted result missing from response register");
`endif

endmodule
